// ----- rtl/core/sfdf_pkg.sv -----
// sfdf_pkg: shared constants, types and saturation helpers for the six-axis
// force decoupling filter. No dependencies.
package sfdf_pkg;

  localparam int AXES       = 6;
  localparam int COEF_FRAC  = 16;
  localparam int ALPHA_FRAC = 16;

  localparam int MODE_W   = 2;
  localparam int CHAN_W   = 4;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 6;
  localparam int COEF_W   = 32;
  localparam int VAL_W    = 32;
  localparam int ALPHA_W  = 17;
  localparam int AXIS_W   = 3;
  localparam int COEF_N   = AXES * AXES;

  localparam int IN_DATA_W = 64;
  localparam int OUT_W     = AXES * SAMPLE_W;

  localparam int PROD_W  = COEF_W + SAMPLE_W;
  localparam int ACC_W   = PROD_W + 3;
  localparam int DIFF_W  = VAL_W + 2;
  localparam int PROD2_W = DIFF_W + ALPHA_W + 1;
  localparam int SAT_W   = PROD2_W;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_FRAME = 2'd0,
    MODE_COEF  = 2'd1,
    MODE_TARE  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_COEF,
    CMD_TARE,
    CMD_SAMPLE,
    CMD_SET
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [AXIS_W-1:0]          slot;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           idx;
    logic signed [COEF_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAC,
    BK_DRAIN
  } back_state_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_W-1:0] x);
    logic [SAT_W-VAL_W:0] top;
    logic signed [VAL_W-1:0] res;
    top = x[SAT_W-1:VAL_W-1];
    if ((&top) || !(|top)) begin
      res = x[VAL_W-1:0];
    end else if (x[SAT_W-1]) begin
      res = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [VAL_W-1:0] x);
    logic [VAL_W-SAMPLE_W:0] top;
    logic signed [SAMPLE_W-1:0] res;
    top = x[VAL_W-1:SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      res = x[SAMPLE_W-1:0];
    end else if (x[VAL_W-1]) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/sfdf_front.sv -----
// sfdf_front: accepts input items, tracks the frame channel order and turns
// items into commands for the back end. Depends on sfdf_pkg.
module sfdf_front import sfdf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [MODE_W-1:0]    in_tuser,
  input  queue_status_t        q_status,
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic [AXIS_W-1:0] exp_r, exp_nxt;
  logic [CHAN_W-1:0] chan;
  logic              accept;
  mode_t             mode;

  assign chan      = in_tdata[3:0];
  assign mode      = mode_t'(in_tuser);
  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    exp_nxt         = exp_r;
    push            = 1'b0;
    push_cmd.kind   = CMD_SAMPLE;
    push_cmd.slot   = exp_r - AXIS_W'(1);
    push_cmd.sample = in_tdata[19:4];
    push_cmd.idx    = in_tdata[25:20];
    push_cmd.value  = in_tdata[57:26];
    if (accept) begin
      unique case (mode)
        MODE_FRAME: begin
          if (chan == CHAN_W'(exp_r)) begin
            push = 1'b1;
            if (exp_r == AXIS_W'(AXES)) begin
              push_cmd.kind = CMD_SET;
              exp_nxt       = AXIS_W'(1);
            end else begin
              push_cmd.kind = CMD_SAMPLE;
              exp_nxt       = exp_r + AXIS_W'(1);
            end
          end else begin
            exp_nxt = AXIS_W'(1);
          end
        end
        MODE_COEF: begin
          push_cmd.kind = CMD_COEF;
          push          = (in_tdata[25:20] < IDX_W'(COEF_N));
        end
        MODE_TARE: begin
          push_cmd.kind = CMD_TARE;
          push          = 1'b1;
        end
        MODE_NONE: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= AXIS_W'(1);
    end else begin
      exp_r <= exp_nxt;
    end
  end

endmodule

// ----- rtl/core/sfdf_queue.sv -----
// sfdf_queue: short command queue between front and back end.
// Depends on sfdf_pkg.
module sfdf_queue import sfdf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          head,
  output queue_status_t q_status
);

  cmd_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_push, do_pop;

  assign q_status.full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign head           = entry_r[rd_ptr_r];
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QUEUE_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/sfdf_back.sv -----
// sfdf_back: coefficient memory, matrix multiply-accumulate pipeline, tare and
// low-pass filter update, and the result register. Depends on sfdf_pkg.
module sfdf_back import sfdf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [ALPHA_W-1:0] cfg_wdata,
  input  cmd_t               head,
  input  queue_status_t      q_status,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata
);

  back_state_t state_r, state_nxt;

  logic [ALPHA_W-1:0] cfg_r;
  logic [ALPHA_W-1:0] alpha;

  logic signed [COEF_W-1:0]   coef_mem [COEF_N];
  logic signed [SAMPLE_W-1:0] raw_r    [AXES];
  logic signed [VAL_W-1:0]    tare_r   [AXES];
  logic signed [VAL_W-1:0]    filt_r   [AXES];
  logic                       tare_pending_r;

  logic [IDX_W-1:0]  addr_r;
  logic [AXIS_W-1:0] row_r, col_r;

  logic mem_we, raw_we, tare_set, issue, out_load;

  // pipeline stages
  logic                     v1_r, v2_r, v3_r, va_r, vb_r, vc_r, fin_r;
  logic [AXIS_W-1:0]        row1_r, col1_r, row2_r, col2_r, row3_r, rowa_r, rowb_r, rowc_r;
  logic signed [COEF_W-1:0] rd_data_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [VAL_W-1:0]  dec_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [SAT_W-1:0]  prod2_r;

  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [SAT_W-1:0]  acc_ext;
  logic signed [DIFF_W-1:0] dec_ext, tare_ext, filt_b_ext;
  logic signed [SAT_W-1:0]  filt_d_ext, filt_sum;

  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_data_r;

  assign alpha      = (cfg_r > ALPHA_ONE) ? ALPHA_ONE : cfg_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign prod_ext   = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_ext    = {{(SAT_W-ACC_W){acc_r[ACC_W-1]}}, acc_r};
  assign dec_ext    = {{(DIFF_W-VAL_W){dec_r[VAL_W-1]}}, dec_r};
  assign tare_ext   = {{(DIFF_W-VAL_W){tare_r[rowa_r][VAL_W-1]}}, tare_r[rowa_r]};
  assign filt_b_ext = {{(DIFF_W-VAL_W){filt_r[rowa_r][VAL_W-1]}}, filt_r[rowa_r]};
  assign filt_d_ext = {{(SAT_W-VAL_W){filt_r[rowc_r][VAL_W-1]}}, filt_r[rowc_r]};
  assign filt_sum   = filt_d_ext + (prod2_r >>> ALPHA_FRAC);

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    mem_we    = 1'b0;
    raw_we    = 1'b0;
    tare_set  = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          unique case (head.kind)
            CMD_COEF: begin
              pop    = 1'b1;
              mem_we = 1'b1;
            end
            CMD_TARE: begin
              pop      = 1'b1;
              tare_set = 1'b1;
            end
            CMD_SAMPLE: begin
              pop    = 1'b1;
              raw_we = 1'b1;
            end
            CMD_SET: begin
              if (!out_valid_r) begin
                pop       = 1'b1;
                raw_we    = 1'b1;
                state_nxt = BK_MAC;
              end
            end
          endcase
        end
      end
      BK_MAC: begin
        issue = 1'b1;
        if (addr_r == IDX_W'(COEF_N-1)) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (fin_r) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= BK_IDLE;
      cfg_r          <= ALPHA_ONE;
      tare_pending_r <= 1'b1;
      addr_r         <= '0;
      row_r          <= '0;
      col_r          <= '0;
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      v3_r           <= 1'b0;
      va_r           <= 1'b0;
      vb_r           <= 1'b0;
      vc_r           <= 1'b0;
      fin_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        tare_r[i] <= '0;
        filt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (tare_set) begin
        tare_pending_r <= 1'b1;
      end else if (out_load) begin
        tare_pending_r <= 1'b0;
      end
      if (issue) begin
        addr_r <= addr_r + IDX_W'(1);
        if (col_r == AXIS_W'(AXES-1)) begin
          col_r <= '0;
          row_r <= row_r + AXIS_W'(1);
        end else begin
          col_r <= col_r + AXIS_W'(1);
        end
      end else begin
        addr_r <= '0;
        row_r  <= '0;
        col_r  <= '0;
      end
      v1_r  <= issue;
      v2_r  <= v1_r;
      v3_r  <= v2_r && (col2_r == AXIS_W'(AXES-1));
      va_r  <= v3_r;
      vb_r  <= va_r;
      vc_r  <= vb_r;
      fin_r <= vc_r && (rowc_r == AXIS_W'(AXES-1));
      if (vb_r && tare_pending_r) begin
        tare_r[rowa_r] <= dec_r;
      end
      if (vc_r) begin
        filt_r[rowc_r] <= sat_val(filt_sum);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // coefficient memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      coef_mem[head.idx] <= head.value;
    end
    rd_data_r <= coef_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (raw_we) begin
      raw_r[head.slot] <= head.sample;
    end
    row1_r <= row_r;
    col1_r <= col_r;
    row2_r <= row1_r;
    col2_r <= col1_r;
    prod_r <= rd_data_r * raw_r[col1_r];
    if (v2_r) begin
      row3_r <= row2_r;
      if (col2_r == '0) begin
        acc_r <= prod_ext;
      end else begin
        acc_r <= acc_r + prod_ext;
      end
    end
    if (v3_r) begin
      rowa_r <= row3_r;
      dec_r  <= sat_val(acc_ext >>> COEF_FRAC);
    end
    if (va_r) begin
      rowb_r <= rowa_r;
      diff_r <= dec_ext - tare_ext - filt_b_ext;
    end
    if (vb_r) begin
      rowc_r  <= rowb_r;
      prod2_r <= $signed({1'b0, alpha}) * diff_r;
    end
    if (out_load) begin
      for (int i = 0; i < AXES; i++) begin
        out_data_r[i*SAMPLE_W +: SAMPLE_W] <= sat_out(filt_r[i]);
      end
    end
  end

endmodule

// ----- rtl/core/six_axis_force_decouple_filter.sv -----
// six_axis_force_decouple_filter: top level, front end, command queue, back end.
// The channel 6 frame completes a set, which the back end then decouples and filters;
// 36 multiply-accumulates share one multiplier, one coefficient a cycle.
// Throughput: one item a cycle into the queue while it is not full; a completed set waits
// for the previous result to be taken, then holds the back end until its result is loaded.
// Reset: control, tare and filter values clear, tare pending set, alpha 65536; no memory clear.
module six_axis_force_decouple_filter import sfdf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // channel, sample, coeff_index, coeff_value, zero pad
  input  logic [IN_DATA_W-1:0] in_tdata,
  // mode
  input  logic [MODE_W-1:0]    in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_we,
  input  logic [ALPHA_W-1:0]   cfg_wdata
);

  queue_status_t q_status;
  logic          push, pop;
  cmd_t          push_cmd, head;

  sfdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  sfdf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  sfdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
